### hdl/cfs_pkg.sv
// Shared types, constants and helpers for the compensated float sum block.
package cfs_pkg;

   localparam int DATA_W      = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int MANT_W      = 56;

   localparam logic [DATA_W-1:0] QNAN64 = 64'h7FF8_0000_0000_0000;
   localparam logic [DATA_W-1:0] QNAN32 = 64'h0000_0000_7FC0_0000;

   typedef enum logic {
      MODE_SP = 1'b0,
      MODE_DP = 1'b1
   } prec_type;

   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              sub;
      prec_type          mode;
   } fadd_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
   } item_type;

   function automatic logic is_nan(input logic [DATA_W-1:0] x, input prec_type m);
      logic r;
      if (m == MODE_DP) begin
         r = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
      end else begin
         r = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      end
      return r;
   endfunction

   function automatic logic [5:0] lzc56(input logic [MANT_W-1:0] x);
      logic [5:0] n;
      n = 6'd56;
      for (int i = 0; i < MANT_W; i++) begin
         if (x[i]) begin
            n = 6'(MANT_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

### hdl/compensated_float_sum.sv
// Compensated (Kahan) floating-point summation unit, binary32 or binary64.
// Each word is taken from the queue, then its four dependent adds go one
// after another through a single 5-stage adder, and then the word commits.
// The input queue keeps accepting words meanwhile while it has room, and
// the result register lets a finished sum wait for the sink. Sum and
// compensation reset to +0, are cleared after each word with tlast and by
// any write to the precision register.
module compensated_float_sum #(
   parameter int QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cfs_pkg::DATA_W-1:0]  req_tdata,   // value_bits
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cfs_pkg::DATA_W-1:0]  rsp_tdata,   // sum_bits
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data  // precision_mode
);
   import cfs_pkg::*;

   prec_type          mode_ff;
   logic              q_valid, q_pop;
   item_type          q_item;
   logic              add_valid, add_res_valid;
   fadd_req_type      add_req;
   logic [DATA_W-1:0] add_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SP;
      end else if (csr_wr_en) begin
         mode_ff <= prec_type'(csr_wr_data);
      end
   end

   cfs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   cfs_fadd u_fadd (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (add_valid),
      .op        (add_req),
      .res_valid (add_res_valid),
      .res_data  (add_res)
   );

   cfs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .clear         (csr_wr_en),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .add_valid     (add_valid),
      .add_req       (add_req),
      .add_res_valid (add_res_valid),
      .add_res       (add_res),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

### hdl/cfs_front.sv
// Input queue: accepts words, drops unused upper bits in binary32 mode.
module cfs_front #(
   parameter int DEPTH = cfs_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfs_pkg::prec_type           mode,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cfs_pkg::DATA_W-1:0]  req_tdata,
   input  logic                        req_tlast,
   output logic                        q_valid,
   output cfs_pkg::item_type           q_item,
   input  logic                        q_pop
);
   import cfs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;
   item_type         entry;

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      entry.last  = req_tlast;
      entry.value = (mode == MODE_DP) ? req_tdata : {32'd0, req_tdata[31:0]};
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### hdl/cfs_fadd.sv
// Five-stage IEEE add/subtract, binary32 or binary64, round to nearest even.
module cfs_fadd (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  cfs_pkg::fadd_req_type       op,
   output logic                        res_valid,
   output logic [cfs_pkg::DATA_W-1:0]  res_data
);
   import cfs_pkg::*;

   // stage 0: unpack, specials, order by magnitude
   logic        dp;
   logic [10:0] ea_raw, eb_raw, ea_eff, eb_eff, emax;
   logic [51:0] fa, fb;
   logic        sa, sb;
   logic [52:0] siga, sigb;
   logic        a_inf, b_inf, a_nan, b_nan, swap;
   logic        spec_in;
   logic [63:0] spec_val_in;

   always_comb begin
      dp     = (op.mode == MODE_DP);
      ea_raw = dp ? op.a[62:52] : {3'd0, op.a[30:23]};
      eb_raw = dp ? op.b[62:52] : {3'd0, op.b[30:23]};
      fa     = dp ? op.a[51:0] : {op.a[22:0], 29'd0};
      fb     = dp ? op.b[51:0] : {op.b[22:0], 29'd0};
      sa     = dp ? op.a[63] : op.a[31];
      sb     = (dp ? op.b[63] : op.b[31]) ^ op.sub;
      emax   = dp ? 11'h7FF : 11'h0FF;
      siga   = {ea_raw != 11'd0, fa};
      sigb   = {eb_raw != 11'd0, fb};
      ea_eff = (ea_raw == 11'd0) ? 11'd1 : ea_raw;
      eb_eff = (eb_raw == 11'd0) ? 11'd1 : eb_raw;
      a_inf  = (ea_raw == emax) && (fa == 52'd0);
      b_inf  = (eb_raw == emax) && (fb == 52'd0);
      a_nan  = (ea_raw == emax) && (fa != 52'd0);
      b_nan  = (eb_raw == emax) && (fb != 52'd0);
      swap   = {eb_eff, sigb} > {ea_eff, siga};
      spec_in = a_nan || b_nan || a_inf || b_inf;
      if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
         spec_val_in = dp ? QNAN64 : QNAN32;
      end else begin
         spec_val_in = dp ? {a_inf ? sa : sb, 11'h7FF, 52'd0}
                          : {32'd0, a_inf ? sa : sb, 8'hFF, 23'd0};
      end
   end

   logic        s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic        s1_sign_ff, s1_sub_ff, s1_spec_ff;
   prec_type    s1_mode_ff;
   logic [63:0] s1_spec_val_ff;
   logic [10:0] s1_ebig_ff, s1_esmall_ff;
   logic [52:0] s1_sigbig_ff, s1_sigsmall_ff;

   always_ff @(posedge clock) begin
      s1_sign_ff     <= swap ? sb : sa;
      s1_sub_ff      <= sa ^ sb;
      s1_spec_ff     <= spec_in;
      s1_spec_val_ff <= spec_val_in;
      s1_mode_ff     <= op.mode;
      s1_ebig_ff     <= swap ? eb_eff : ea_eff;
      s1_esmall_ff   <= swap ? ea_eff : eb_eff;
      s1_sigbig_ff   <= swap ? sigb : siga;
      s1_sigsmall_ff <= swap ? siga : sigb;
   end

   // stage 1: align the smaller operand, keep a sticky bit
   logic [10:0]       diff;
   logic [5:0]        d6;
   logic              far;
   logic [MANT_W-1:0] ext, shifted, small_in;
   logic              sticky;

   always_comb begin
      diff    = s1_ebig_ff - s1_esmall_ff;
      d6      = diff[5:0];
      far     = (diff >= 11'd56);
      ext     = {s1_sigsmall_ff, 3'd0};
      shifted = far ? '0 : (ext >> d6);
      sticky  = far ? (|ext) : (|(ext & ~({MANT_W{1'b1}} << d6)));
      small_in = {shifted[MANT_W-1:1], shifted[0] | sticky};
   end

   logic              s2_sign_ff, s2_sub_ff, s2_spec_ff;
   prec_type          s2_mode_ff;
   logic [63:0]       s2_spec_val_ff;
   logic [10:0]       s2_e_ff;
   logic [MANT_W-1:0] s2_big_ff, s2_small_ff;

   always_ff @(posedge clock) begin
      s2_sign_ff     <= s1_sign_ff;
      s2_sub_ff      <= s1_sub_ff;
      s2_spec_ff     <= s1_spec_ff;
      s2_spec_val_ff <= s1_spec_val_ff;
      s2_mode_ff     <= s1_mode_ff;
      s2_e_ff        <= s1_ebig_ff;
      s2_big_ff      <= {s1_sigbig_ff, 3'd0};
      s2_small_ff    <= small_in;
   end

   // stage 2: magnitude add or subtract
   logic [MANT_W:0] sum_in;
   logic            sign_in;

   always_comb begin
      sum_in = s2_sub_ff ? ({1'b0, s2_big_ff} - {1'b0, s2_small_ff})
                         : ({1'b0, s2_big_ff} + {1'b0, s2_small_ff});
      sign_in = (sum_in == '0) ? (s2_sign_ff & ~s2_sub_ff) : s2_sign_ff;
   end

   logic            s3_sign_ff, s3_spec_ff;
   prec_type        s3_mode_ff;
   logic [63:0]     s3_spec_val_ff;
   logic [11:0]     s3_e_ff;
   logic [MANT_W:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      s3_sign_ff     <= sign_in;
      s3_spec_ff     <= s2_spec_ff;
      s3_spec_val_ff <= s2_spec_val_ff;
      s3_mode_ff     <= s2_mode_ff;
      s3_e_ff        <= {1'b0, s2_e_ff};
      s3_sum_ff      <= sum_in;
   end

   // stage 3: leading zero count, limited so that tiny results stay subnormal
   logic [MANT_W-1:0] m_in;
   logic [11:0]       e_in, lim;
   logic [5:0]        lz, sh_in;

   always_comb begin
      lim = s3_e_ff - 12'd1;
      lz  = lzc56(s3_sum_ff[MANT_W-1:0]);
      if (s3_sum_ff[MANT_W]) begin
         m_in  = {s3_sum_ff[MANT_W:2], s3_sum_ff[1] | s3_sum_ff[0]};
         e_in  = s3_e_ff + 12'd1;
         sh_in = '0;
      end else begin
         m_in  = s3_sum_ff[MANT_W-1:0];
         e_in  = s3_e_ff;
         sh_in = ({6'd0, lz} < lim) ? lz : lim[5:0];
      end
   end

   logic              s4_sign_ff, s4_spec_ff;
   prec_type          s4_mode_ff;
   logic [63:0]       s4_spec_val_ff;
   logic [11:0]       s4_e_ff;
   logic [5:0]        s4_sh_ff;
   logic [MANT_W-1:0] s4_m_ff;

   always_ff @(posedge clock) begin
      s4_sign_ff     <= s3_sign_ff;
      s4_spec_ff     <= s3_spec_ff;
      s4_spec_val_ff <= s3_spec_val_ff;
      s4_mode_ff     <= s3_mode_ff;
      s4_e_ff        <= e_in;
      s4_sh_ff       <= sh_in;
      s4_m_ff        <= m_in;
   end

   // stage 4: normalize, round, pack
   logic [MANT_W-1:0] mn;
   logic [11:0]       en, ex64, ex32;
   logic [53:0]       mr64;
   logic [24:0]       mr32;
   logic              inc64, inc32;
   logic [51:0]       fr64;
   logic [22:0]       fr32;
   logic [63:0]       res_in;

   always_comb begin
      mn    = s4_m_ff << s4_sh_ff;
      en    = s4_e_ff - {6'd0, s4_sh_ff};
      inc64 = mn[2] & ((|mn[1:0]) | mn[3]);
      mr64  = {1'b0, mn[55:3]} + {53'd0, inc64};
      inc32 = mn[31] & ((|mn[30:0]) | mn[32]);
      mr32  = {1'b0, mn[55:32]} + {24'd0, inc32};
      if (mr64[53]) begin
         ex64 = en + 12'd1;
         fr64 = '0;
      end else begin
         ex64 = mr64[52] ? en : 12'd0;
         fr64 = mr64[51:0];
      end
      if (mr32[24]) begin
         ex32 = en + 12'd1;
         fr32 = '0;
      end else begin
         ex32 = mr32[23] ? en : 12'd0;
         fr32 = mr32[22:0];
      end
      if (s4_spec_ff) begin
         res_in = s4_spec_val_ff;
      end else if (s4_mode_ff == MODE_DP) begin
         res_in = (ex64 >= 12'd2047) ? {s4_sign_ff, 11'h7FF, 52'd0}
                                     : {s4_sign_ff, ex64[10:0], fr64};
      end else begin
         res_in = (ex32 >= 12'd255) ? {32'd0, s4_sign_ff, 8'hFF, 23'd0}
                                    : {32'd0, s4_sign_ff, ex32[7:0], fr32};
      end
   end

   always_ff @(posedge clock) begin
      res_data <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         res_valid <= 1'b0;
      end else begin
         s1_vld_ff <= op_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         res_valid <= s4_vld_ff;
      end
   end

endmodule

### hdl/cfs_back.sv
// Kahan sequencer: issues the four dependent adds of each word, holds sum and compensation.
module cfs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cfs_pkg::prec_type           mode,
   input  logic                        clear,
   input  logic                        q_valid,
   input  cfs_pkg::item_type           q_item,
   output logic                        q_pop,
   output logic                        add_valid,
   output cfs_pkg::fadd_req_type       add_req,
   input  logic                        add_res_valid,
   input  logic [cfs_pkg::DATA_W-1:0]  add_res,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cfs_pkg::DATA_W-1:0]  rsp_tdata
);
   import cfs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      OP_Y = 2'd0,
      OP_T = 2'd1,
      OP_D = 2'd2,
      OP_C = 2'd3
   } op_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] v_ff, sum_ff, comp_ff, y_ff, t_ff, d_ff, nc_ff;
   logic              last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              out_free;
   logic              commit;
   logic [DATA_W-1:0] canon;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign add_valid  = (state_ff == ST_ISSUE);
   assign commit     = (state_ff == ST_FINISH) && (!last_ff || out_free);
   assign canon      = is_nan(t_ff, mode) ? ((mode == MODE_DP) ? QNAN64 : QNAN32) : t_ff;

   always_comb begin
      add_req.mode = mode;
      case (op_ff)
         OP_Y: begin
            add_req.a = v_ff; add_req.b = comp_ff; add_req.sub = 1'b1;
         end
         OP_T: begin
            add_req.a = sum_ff; add_req.b = y_ff; add_req.sub = 1'b0;
         end
         OP_D: begin
            add_req.a = t_ff; add_req.b = sum_ff; add_req.sub = 1'b1;
         end
         default: begin
            add_req.a = d_ff; add_req.b = y_ff; add_req.sub = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_ISSUE;
               op_in    = OP_Y;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (add_res_valid) begin
               if (op_ff == OP_C) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ISSUE;
                  op_in    = op_type'(op_ff + 2'd1);
               end
            end
         end
         ST_FINISH: begin
            if (commit) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_Y;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         comp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear || (commit && last_ff)) begin
            sum_ff  <= '0;
            comp_ff <= '0;
         end else if (commit) begin
            sum_ff  <= t_ff;
            comp_ff <= nc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         v_ff    <= q_item.value;
         last_ff <= q_item.last;
      end
      if ((state_ff == ST_WAIT) && add_res_valid) begin
         case (op_ff)
            OP_Y:    y_ff  <= add_res;
            OP_T:    t_ff  <= add_res;
            OP_D:    d_ff  <= add_res;
            default: nc_ff <= add_res;
         endcase
      end
      if (commit && last_ff) begin
         rsp_data_ff <= canon;
      end
   end

endmodule

### hdl/cfs_checker.sv
// Port-level checks for the compensated float sum, bound to the top level.
module cfs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [cfs_pkg::DATA_W-1:0]  rsp_tdata,
   input logic                        csr_wr_en,
   input logic                        csr_wr_data
);
   import cfs_pkg::*;

   logic       mode_ff;
   logic [3:0] pending_ff, pending_in;
   logic       in_last, out_word;

   assign in_last  = req_tvalid && req_tready && req_tlast;
   assign out_word = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (in_last && !out_word) begin
         pending_in = pending_ff + 4'd1;
      end else if (out_word && !in_last) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("result word without a closing input word");

   a_sp_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !mode_ff |-> rsp_tdata[63:32] == 32'd0)
      else $error("binary32 result has upper bits set");

   a_qnan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_nan(rsp_tdata, prec_type'(mode_ff)) |->
         (rsp_tdata == QNAN64) || (rsp_tdata == QNAN32))
      else $error("NaN result is not canonical");

endmodule

bind compensated_float_sum cfs_checker u_cfs_checker (.*);
